// ===== rtl/svwps_pkg.sv =====
// ----------------------------------------------------------------------------
// svwps_pkg
// Shared types and constants of the sixteen-voice wavetable and PCM synth.
// ----------------------------------------------------------------------------
package svwps_pkg;

  localparam int VOICES_DEF        = 16;
  localparam int ROM_ADDR_BITS_DEF = 20;
  localparam int RAM_BYTES         = 8192;
  localparam int RAM_ADDR_W        = 13;
  localparam int ROM_FIELD_W       = 20;
  localparam int Q_DEPTH           = 2;
  localparam int Q_PTR_W           = 1;
  localparam int Q_CNT_W           = 2;
  localparam int VOL_UNIT          = 32 * 256 / 30;
  localparam logic [31:0] CLOCK_RATIO_RESET = 32'h0001_0000;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_LOAD  = 2'd3;

  localparam logic CFG_CLOCK_RATIO = 1'b0;
  localparam logic CFG_ADDRESS_XOR = 1'b1;

  typedef struct packed {
    logic [1:0]             op;
    logic [RAM_ADDR_W-1:0]  addr;
    logic [7:0]             data;
    logic [ROM_FIELD_W-1:0] rom_addr;
    logic                   keyon;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

// ===== rtl/svwps_ifs.sv =====
// ----------------------------------------------------------------------------
// svwps_ifs
// Valid/ready channels for synth items and results.
// ----------------------------------------------------------------------------
interface svwps_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        operation;
  logic [svwps_pkg::RAM_ADDR_W-1:0]  bus_address;
  logic [7:0]                        write_data;
  logic [svwps_pkg::ROM_FIELD_W-1:0] rom_address;

  modport source (output valid, operation, bus_address, write_data, rom_address,
                  input ready);
  modport sink (input valid, operation, bus_address, write_data, rom_address,
                output ready);
endinterface

interface svwps_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         read_data;
  logic signed [15:0] mixed_sample;
  logic               sample_valid;

  modport source (output valid, read_data, mixed_sample, sample_valid, input ready);
  modport sink (input valid, read_data, mixed_sample, sample_valid, output ready);
endinterface

// ===== rtl/svwps_front.sv =====
// ----------------------------------------------------------------------------
// svwps_front
// Accepts items, applies the address XOR, flags key-on candidates, queues them.
// ----------------------------------------------------------------------------
module svwps_front #(
  parameter int VOICES = svwps_pkg::VOICES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  svwps_in_if.sink                         in_ch,
  input  logic [svwps_pkg::RAM_ADDR_W-1:0] address_xor,
  input  svwps_pkg::back_ctl_t             ctl,
  output svwps_pkg::queue_head_t           head
);

  svwps_pkg::item_t                  q_mem [svwps_pkg::Q_DEPTH];
  logic [svwps_pkg::Q_PTR_W-1:0]     wr_ptr;
  logic [svwps_pkg::Q_PTR_W-1:0]     rd_ptr;
  logic [svwps_pkg::Q_CNT_W-1:0]     count;
  svwps_pkg::item_t                  cls;
  logic [svwps_pkg::RAM_ADDR_W-1:0]  eff_addr;
  logic                              push;
  logic                              pop;

  assign in_ch.ready = (count != svwps_pkg::Q_CNT_W'(svwps_pkg::Q_DEPTH)) && !ctl.clearing;
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = ctl.pop && (count != '0);

  always_comb begin
    eff_addr     = in_ch.bus_address ^ address_xor;
    cls.op       = in_ch.operation;
    cls.addr     = eff_addr;
    cls.data     = in_ch.write_data;
    cls.rom_addr = in_ch.rom_address;
    cls.keyon    = (32'(eff_addr[svwps_pkg::RAM_ADDR_W-1:3]) < VOICES) &&
                   (eff_addr[2:0] == 3'd0) && in_ch.write_data[0];
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + Q_CNT_W_ONE(push) - Q_CNT_W_ONE(pop);
    end
  end

  function automatic logic [svwps_pkg::Q_CNT_W-1:0] Q_CNT_W_ONE(input logic b);
    Q_CNT_W_ONE = {{(svwps_pkg::Q_CNT_W-1){1'b0}}, b};
  endfunction

  assign head.valid = (count != '0);
  assign head.item  = q_mem[rd_ptr];

endmodule

// ===== rtl/svwps_back.sv =====
// ----------------------------------------------------------------------------
// svwps_back
// Executes queued items: RAM access, ROM load, and the voice-by-voice tick.
// ----------------------------------------------------------------------------
module svwps_back #(
  parameter int VOICES        = svwps_pkg::VOICES_DEF,
  parameter int ROM_ADDR_BITS = svwps_pkg::ROM_ADDR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [31:0]            clock_ratio,
  input  svwps_pkg::queue_head_t head,
  output svwps_pkg::back_ctl_t   ctl,
  svwps_out_if.source            out_ch
);

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW     = svwps_pkg::RAM_ADDR_W;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RDW   = 4'd2;
  localparam logic [3:0] S_WRW   = 4'd3;
  localparam logic [3:0] S_DONE  = 4'd4;
  localparam logic [3:0] S_VREG  = 4'd5;
  localparam logic [3:0] S_VCHK  = 4'd6;
  localparam logic [3:0] S_V1    = 4'd7;
  localparam logic [3:0] S_V2    = 4'd8;
  localparam logic [3:0] S_MAC   = 4'd9;
  localparam logic [3:0] S_ACC   = 4'd10;

  logic [3:0]               state;
  logic [AW-1:0]            clr_cnt;
  svwps_pkg::item_t         cur;
  logic [7:0]               rd_reg;
  logic [15:0]              acc;
  logic [VIDX_W-1:0]        v;
  logic [2:0]               k;
  logic [7:0]               r [6];
  logic [7:0]               eb;
  logic signed [7:0]        mdata;
  logic [13:0]              mvol;
  logic signed [22:0]       cprod;
  logic [47:0]              prod;
  logic [31:0]              sp [VOICES];
  logic [31:0]              ep [VOICES];

  logic [7:0]               ram [svwps_pkg::RAM_BYTES];
  logic [7:0]               ram_q;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [7:0]               ram_wdata;
  logic [AW-1:0]            ram_raddr;

  logic [7:0]               rom [2**ROM_ADDR_BITS];
  logic [7:0]               rom_q;
  logic [ROM_ADDR_BITS-1:0] rom_raddr;

  logic [AW-1:0]            vbase;
  logic [25:0]              pos;
  logic [25:0]              pend;
  logic                     pcm_end;
  logic                     wave_end;
  logic [4:0]               freq;
  logic [15:0]              mul_b;
  logic [4:0]               r1_nib;
  logic [22:0]              cbias;
  logic [22:0]              csum;
  logic                     last_v;

  always_comb begin
    vbase    = {{(AW-3-VIDX_W){1'b0}}, v, 3'd0};
    pos      = {6'd0, r[4], 12'd0} + {2'd0, sp[v][31:8]};
    pend     = {5'd0, (9'h100 - {1'b0, r[5]}), 12'd0};
    pcm_end  = (pos >= pend);
    wave_end = r[0][2] && (ep[v][31:16] >= 16'h0080);
    freq     = (r[2][4:0] == 5'd0) ? 5'd4 : r[2][4:0];
    mul_b    = r[0][1] ? {r[3], r[2]} : {11'd0, freq};
    r1_nib   = {1'b0, r[1][7:4]} + {1'b0, r[1][3:0]};
    cbias    = cprod[22] ? 23'd255 : 23'd0;
    csum     = 23'(cprod) + cbias;
    last_v   = (32'(v) == VOICES - 1);
    rom_raddr = pos[ROM_ADDR_BITS-1:0];
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur.addr;
    ram_wdata = cur.data;
    ram_raddr = head.item.addr;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = 8'd0;
      end
      S_WRW: ram_we = 1'b1;
      S_VREG: ram_raddr = vbase | {{(AW-3){1'b0}}, k};
      S_VCHK: begin
        ram_raddr = {1'b0, r[5][4:0], ep[v][22:16]};
        if (r[0][0] && (r[0][1] ? wave_end : pcm_end)) begin
          ram_we    = 1'b1;
          ram_waddr = vbase;
          ram_wdata = r[0] & 8'hfe;
        end
      end
      S_V1: ram_raddr = {1'b1, r[1][4:0], sp[v][14:8]};
      default: ram_raddr = head.item.addr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ram_we) ram[ram_waddr] <= ram_wdata;
    ram_q <= ram[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && head.valid && head.item.op == svwps_pkg::OP_LOAD) begin
      rom[head.item.rom_addr[ROM_ADDR_BITS-1:0]] <= head.item.data;
    end
    rom_q <= rom[rom_raddr];
  end

  assign ctl.pop      = (state == S_IDLE);
  assign ctl.clearing = (state == S_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      out_ch.valid <= 1'b0;
      for (int i = 0; i < VOICES; i++) begin
        sp[i] <= '0;
        ep[i] <= '0;
      end
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_DONE) out_ch.valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(svwps_pkg::RAM_BYTES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (head.valid) begin
            cur <= head.item;
            acc <= '0;
            v   <= '0;
            k   <= '0;
            case (head.item.op)
              svwps_pkg::OP_READ:  state <= S_RDW;
              svwps_pkg::OP_WRITE: state <= S_RDW;
              svwps_pkg::OP_TICK:  state <= S_VREG;
              default:             state <= S_DONE;
            endcase
          end
        end
        S_RDW: begin
          rd_reg <= ram_q;
          state  <= (cur.op == svwps_pkg::OP_WRITE) ? S_WRW : S_DONE;
        end
        S_WRW: begin
          if (cur.keyon && !rd_reg[0]) begin
            sp[cur.addr[VIDX_W+2:3]] <= '0;
            ep[cur.addr[VIDX_W+2:3]] <= '0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid        <= 1'b1;
            out_ch.read_data    <= (cur.op == svwps_pkg::OP_READ) ? rd_reg : 8'd0;
            out_ch.mixed_sample <= (cur.op == svwps_pkg::OP_TICK) ? acc : 16'd0;
            out_ch.sample_valid <= (cur.op == svwps_pkg::OP_TICK);
            state               <= S_IDLE;
          end
        end
        S_VREG: begin
          if (k != 3'd0) r[k - 3'd1] <= ram_q;
          k <= k + 3'd1;
          if (k == 3'd6) state <= S_VCHK;
        end
        S_VCHK: begin
          prod <= clock_ratio * mul_b;
          if (!r[0][0] || (r[0][1] ? wave_end : pcm_end)) begin
            k <= '0;
            v <= v + 1'b1;
            state <= last_v ? S_DONE : S_VREG;
          end else begin
            state <= S_V1;
          end
        end
        S_V1: begin
          if (r[0][1]) begin
            eb    <= ram_q;
            sp[v] <= sp[v] + {11'd0, prod[47:27]};
            prod  <= clock_ratio * {8'd0, r[4]};
            state <= S_V2;
          end else begin
            sp[v] <= sp[v] + {5'd0, prod[47:21]};
            mdata <= rom_q;
            mvol  <= 14'(r1_nib * svwps_pkg::VOL_UNIT);
            state <= S_MAC;
          end
        end
        S_V2: begin
          ep[v] <= ep[v] + {3'd0, prod[47:19]};
          mdata <= ram_q;
          mvol  <= 14'(({1'b0, eb[7:4]} + {1'b0, eb[3:0]}) * svwps_pkg::VOL_UNIT);
          state <= S_MAC;
        end
        S_MAC: begin
          cprod <= 23'(mdata * $signed({1'b0, mvol}));
          state <= S_ACC;
        end
        S_ACC: begin
          acc   <= acc + {csum[22], csum[22:8]};
          k     <= '0;
          v     <= v + 1'b1;
          state <= last_v ? S_DONE : S_VREG;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/sixteen_voice_wavetable_pcm_synth.sv =====
// ----------------------------------------------------------------------------
// sixteen_voice_wavetable_pcm_synth
// Sixteen-voice wavetable and PCM sound generator behind a byte RAM.
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_ch    in   operation, bus_address, write_data, rom_address
// out_ch   out  read_data, mixed_sample, sample_valid
// cfg_*    in   cfg_index 0 clock_ratio, 1 address_xor
//
// A bus write is a read-modify of the voice status byte through the single
// RAM read port. A tick walks the voices one at a time; keyed-off voices
// skip the PCM and waveform steps.
// After reset a clearing pass zeroes all 8192 RAM bytes; no item is
// taken then. A two-entry queue lets input continue while results stall.
// ----------------------------------------------------------------------------
module sixteen_voice_wavetable_pcm_synth #(
  parameter int VOICES        = svwps_pkg::VOICES_DEF,
  parameter int ROM_ADDR_BITS = svwps_pkg::ROM_ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  svwps_in_if.sink    in_ch,
  svwps_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  logic [31:0]                       clock_ratio;
  logic [svwps_pkg::RAM_ADDR_W-1:0]  address_xor;
  svwps_pkg::queue_head_t            head;
  svwps_pkg::back_ctl_t              ctl;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ratio <= svwps_pkg::CLOCK_RATIO_RESET;
      address_xor <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        svwps_pkg::CFG_CLOCK_RATIO: clock_ratio <= cfg_wdata;
        svwps_pkg::CFG_ADDRESS_XOR:
          address_xor <= cfg_wdata[svwps_pkg::RAM_ADDR_W-1:0];
        default: clock_ratio <= clock_ratio;
      endcase
    end
  end

  svwps_front #(.VOICES(VOICES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .address_xor (address_xor),
    .ctl         (ctl),
    .head        (head)
  );

  svwps_back #(.VOICES(VOICES), .ROM_ADDR_BITS(ROM_ADDR_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .clock_ratio (clock_ratio),
    .head        (head),
    .ctl         (ctl),
    .out_ch      (out_ch)
  );

endmodule
